[hw/rtl/dcds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcds_pkg
// Shared types and constants of the descriptor chain DMA sequencer.
// ----------------------------------------------------------------------------
package dcds_pkg;

    localparam int ADDR_W  = 16;
    localparam int COUNT_W = 16;
    localparam int DATA_W  = 32;
    localparam int NEXT_W  = 4;
    localparam int NEXT_N  = 1 << NEXT_W;
    localparam int MODE_W  = 2;
    localparam int KIND_W  = 2;
    localparam int OP_W    = 2;

    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_SUSPENDED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRANSFER  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORWARD   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WAIT      = 2'd3;

    localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    typedef struct packed {
        logic [NEXT_W-1:0]  next;
        logic [ADDR_W-1:0]  start;
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
        logic [ADDR_W-1:0]  stride;
    } desc_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               enable;
        logic [DATA_W-1:0]  stream_data;
        desc_t              desc;
    } in_item_t;

    typedef struct packed {
        logic [OP_W-1:0]    mem_op;
        logic [ADDR_W-1:0]  mem_addr;
        logic [DATA_W-1:0]  write_data;
        logic               stream_zero;
        logic               done_res;
        logic               load_rejected;
    } out_item_t;

    typedef struct packed {
        logic exec;
        logic fetch;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_fetch;
    } ctl_sts_t;

endpackage

[hw/rtl/dcds_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcds_in_if / dcds_out_if
// Valid/ready channels for requests and results of the sequencer.
// ----------------------------------------------------------------------------
interface dcds_in_if import dcds_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic               enable;
    logic [DATA_W-1:0]  stream_data;
    logic [NEXT_W-1:0]  desc_next;
    logic [ADDR_W-1:0]  desc_start;
    logic [MODE_W-1:0]  desc_mode;
    logic [COUNT_W-1:0] desc_count;
    logic [ADDR_W-1:0]  desc_stride;

    modport source (
        output valid, kind, enable, stream_data, desc_next, desc_start,
               desc_mode, desc_count, desc_stride,
        input  ready
    );
    modport sink (
        input  valid, kind, enable, stream_data, desc_next, desc_start,
               desc_mode, desc_count, desc_stride,
        output ready
    );
endinterface

interface dcds_out_if import dcds_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   mem_op;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] write_data;
    logic              stream_zero;
    logic              done_res;
    logic              load_rejected;

    modport source (
        output valid, mem_op, mem_addr, write_data, stream_zero, done_res,
               load_rejected,
        input  ready
    );
    modport sink (
        input  valid, mem_op, mem_addr, write_data, stream_zero, done_res,
               load_rejected,
        output ready
    );
endinterface

[hw/rtl/descriptor_chain_dma_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_chain_dma_sequencer_top
// Descriptor chain DMA sequencer, one direction, one result per request.
//
//   channel   dir   handshake      contents
//   item      in    valid/ready    kind, enable, stream word, descriptor
//   result    out   valid/ready    memory op, address, data, flags
//   cfg       in    cfg_we         direction bit
//
// a tick that ends a descriptor is followed by a fetch step, the descriptor
// table read of the next chain entry, during which no request is taken.
// the result is registered and shows in the cycle after the request is taken.
// a new request is taken while the held result leaves on the same edge.
// reset clears all control state; the table needs no clearing pass since
// entries at or above the fill count read as suspended.
// ----------------------------------------------------------------------------
module descriptor_chain_dma_sequencer_top import dcds_pkg::*; #(
    parameter int DESC_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    dcds_in_if.sink    item,
    dcds_out_if.source result
);

    ctl_cmd_t  cmd;
    ctl_sts_t  sts;
    in_item_t  in_item;
    out_item_t out_item;

    assign in_item.kind        = item.kind;
    assign in_item.enable      = item.enable;
    assign in_item.stream_data = item.stream_data;
    assign in_item.desc.next   = item.desc_next;
    assign in_item.desc.start  = item.desc_start;
    assign in_item.desc.mode   = item.desc_mode;
    assign in_item.desc.count  = item.desc_count;
    assign in_item.desc.stride = item.desc_stride;

    dcds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    dcds_datapath #(
        .DESC_DEPTH (DESC_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (in_item),
        .out_item  (out_item)
    );

    assign result.mem_op        = out_item.mem_op;
    assign result.mem_addr      = out_item.mem_addr;
    assign result.write_data    = out_item.write_data;
    assign result.stream_zero   = out_item.stream_zero;
    assign result.done_res      = out_item.done_res;
    assign result.load_rejected = out_item.load_rejected;

endmodule

[hw/rtl/dcds_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcds_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dcds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/dcds_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcds_ctrl
// Request/result handshake and the state machine that sequences a step.
// ----------------------------------------------------------------------------
module dcds_ctrl import dcds_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output ctl_cmd_t cmd,
    input  ctl_sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FETCH = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // a new request may enter while the held result leaves
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign cmd.exec  = accept;
    assign cmd.fetch = (state_reg == ST_FETCH);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && sts.need_fetch)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/dcds_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcds_datapath
// Descriptor table, active descriptor copy, address and count registers.
// ----------------------------------------------------------------------------
module dcds_datapath import dcds_pkg::*; #(
    parameter int DESC_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  ctl_cmd_t  cmd,
    output ctl_sts_t  sts,
    input  in_item_t  in_item,
    output out_item_t out_item
);

    localparam int IDX_W  = $clog2(DESC_DEPTH);
    localparam int LCNT_W = $clog2(DESC_DEPTH + 1);
    localparam logic [LCNT_W-1:0] FULL_COUNT = LCNT_W'(DESC_DEPTH);

    logic               direction_reg;
    logic [LCNT_W-1:0]  loaded_reg, loaded_next;
    logic [IDX_W-1:0]   active_reg, active_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;
    logic               done_reg, done_next;
    logic [NEXT_W-1:0]  next_reg, next_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [ADDR_W-1:0]  stride_reg, stride_next;
    logic               fetch_valid_reg;
    out_item_t          out_reg, out_next;

    logic [IDX_W-1:0]   next_map [NEXT_N];
    logic [IDX_W-1:0]   follow_idx;
    logic [COUNT_W-1:0] remain_dec;
    logic               table_full;
    logic               ram_we;
    desc_t              ram_rdata;
    desc_t              fetched;

    // next index folded into the table depth
    for (genvar g = 0; g < NEXT_N; g++)
    begin : g_next_map
        assign next_map[g] = IDX_W'(g % DESC_DEPTH);
    end

    assign follow_idx = next_map[next_reg];
    assign remain_dec = remain_reg - COUNT_W'(1);
    assign table_full = (loaded_reg == FULL_COUNT);
    assign ram_we     = cmd.exec && (in_item.kind == KIND_LOAD) && !table_full;

    dcds_ram #(
        .WIDTH ($bits(desc_t)),
        .DEPTH (DESC_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (loaded_reg[IDX_W-1:0]),
        .wdata (in_item.desc),
        .raddr (follow_idx),
        .rdata (ram_rdata)
    );

    // entries at or above the fill count read as suspended zeros
    assign fetched = fetch_valid_reg ? ram_rdata : '0;

    always_comb
    begin
        loaded_next     = loaded_reg;
        active_next     = active_reg;
        addr_next       = addr_reg;
        remain_next     = remain_reg;
        done_next       = done_reg;
        next_next       = next_reg;
        mode_next       = mode_reg;
        stride_next     = stride_reg;
        out_next        = out_reg;
        sts.need_fetch  = 1'b0;

        if (cmd.exec)
        begin
            out_next = '0;
            unique case (in_item.kind)
                KIND_RESTART:
                begin
                    loaded_next = '0;
                    active_next = '0;
                    addr_next   = '0;
                    remain_next = '0;
                    done_next   = 1'b0;
                    next_next   = '0;
                    mode_next   = MODE_SUSPENDED;
                    stride_next = '0;
                end
                KIND_LOAD:
                begin
                    if (table_full)
                    begin
                        out_next.load_rejected = 1'b1;
                    end
                    else
                    begin
                        loaded_next = loaded_reg + LCNT_W'(1);
                        if (loaded_reg == '0)
                        begin
                            active_next = '0;
                            addr_next   = in_item.desc.start;
                            remain_next = in_item.desc.count;
                            next_next   = in_item.desc.next;
                            mode_next   = in_item.desc.mode;
                            stride_next = in_item.desc.stride;
                        end
                        else if (active_reg == loaded_reg[IDX_W-1:0])
                        begin
                            // the chain sits on this entry: its next, mode and stride take effect now
                            next_next   = in_item.desc.next;
                            mode_next   = in_item.desc.mode;
                            stride_next = in_item.desc.stride;
                        end
                    end
                end
                KIND_TICK:
                begin
                    if (in_item.enable && (mode_reg != MODE_SUSPENDED))
                    begin
                        if (mode_reg == MODE_TRANSFER)
                        begin
                            out_next.mem_addr = addr_reg;
                            if (direction_reg)
                            begin
                                out_next.mem_op     = OP_WRITE;
                                out_next.write_data = in_item.stream_data;
                            end
                            else
                            begin
                                out_next.mem_op = OP_READ;
                            end
                            addr_next = addr_reg + stride_reg;
                        end
                        else
                        begin
                            out_next.stream_zero = !direction_reg;
                        end
                        remain_next = remain_dec;
                        if (remain_dec == '0)
                        begin
                            done_next      = 1'b1;
                            active_next    = follow_idx;
                            sts.need_fetch = 1'b1;
                        end
                    end
                    else
                    begin
                        out_next.stream_zero = !direction_reg;
                    end
                end
                KIND_UNUSED:
                begin
                end
            endcase
            out_next.done_res = done_next;
        end
        else if (cmd.fetch)
        begin
            addr_next   = fetched.start;
            remain_next = fetched.count;
            next_next   = fetched.next;
            mode_next   = fetched.mode;
            stride_next = fetched.stride;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= 1'b0;
            loaded_reg      <= '0;
            active_reg      <= '0;
            addr_reg        <= '0;
            remain_reg      <= '0;
            done_reg        <= 1'b0;
            next_reg        <= '0;
            mode_reg        <= MODE_SUSPENDED;
            stride_reg      <= '0;
            fetch_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                direction_reg <= cfg_wdata;
            end
            loaded_reg      <= loaded_next;
            active_reg      <= active_next;
            addr_reg        <= addr_next;
            remain_reg      <= remain_next;
            done_reg        <= done_next;
            next_reg        <= next_next;
            mode_reg        <= mode_next;
            stride_reg      <= stride_next;
            fetch_valid_reg <= (LCNT_W'(follow_idx) < loaded_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_item = out_reg;

endmodule

[hw/rtl/dcds_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcds_checker
// Port level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module dcds_checker import dcds_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [KIND_W-1:0] kind,
    input logic              out_valid,
    input logic              out_ready,
    input logic [OP_W-1:0]   mem_op,
    input logic [ADDR_W-1:0] mem_addr,
    input logic [DATA_W-1:0] write_data,
    input logic              stream_zero,
    input logic              done_res,
    input logic              load_rejected
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mem_op)
            && $stable(mem_addr) && $stable(write_data) && $stable(done_res))
        else $error("result changed while stalled");

    // restart yields an all zero result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_RESTART) |=>
            out_valid && (mem_op == OP_NONE) && !done_res && !stream_zero
            && !load_rejected)
        else $error("restart result not cleared");

    // no access means no address and no data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mem_op == OP_NONE) |-> (mem_addr == '0) && (write_data == '0))
        else $error("idle result carries address or data");

    // an access excludes the idle stream and the rejected load
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mem_op != OP_NONE) |-> !stream_zero && !load_rejected
            && (mem_op == OP_READ || mem_op == OP_WRITE))
        else $error("access result with conflicting flags");

    // the done flag is sticky until a restart is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res && !(in_valid && in_ready && kind == KIND_RESTART)
            ##1 out_valid |-> done_res)
        else $error("done flag dropped without restart");

endmodule

bind descriptor_chain_dma_sequencer_top dcds_checker u_dcds_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .kind          (item.kind),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .mem_op        (result.mem_op),
    .mem_addr      (result.mem_addr),
    .write_data    (result.write_data),
    .stream_zero   (result.stream_zero),
    .done_res      (result.done_res),
    .load_rejected (result.load_rejected)
);

[tb/sv/dcds_sequence_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcds_sequence_monitor
// Watches the request and result channels and the direction register port,
// runs its own copy of the descriptor chain to predict one result for each
// accepted request, and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module dcds_sequence_monitor import dcds_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    dcds_in_if   item,
    dcds_out_if  result,
    output int   fail_count,
    output int   outstanding,
    output int   results_checked,
    output int   reads_seen,
    output int   writes_seen,
    output int   descs_completed,
    output int   loads_refused
);

    desc_t              chain_tbl [NEXT_N];
    int                 fill_level;
    logic [NEXT_W-1:0]  active_idx;
    logic [ADDR_W-1:0]  cur_addr;
    logic [COUNT_W-1:0] ticks_left;
    logic               done_flag;
    logic               dir_s2mm;
    out_item_t          expected_q [$];

    function automatic void clear_table();
        for (int i = 0; i < NEXT_N; i++)
        begin
            chain_tbl[i] = '0;
        end
    endfunction

    function automatic void clear_chain();
        clear_table();
        fill_level = 0;
        active_idx = '0;
        cur_addr   = '0;
        ticks_left = '0;
        done_flag  = 1'b0;
    endfunction

    function automatic void enter_desc(input logic [NEXT_W-1:0] idx);
        active_idx = idx;
        cur_addr   = chain_tbl[idx].start;
        ticks_left = chain_tbl[idx].count;
    endfunction

    function automatic out_item_t step_sequencer(input in_item_t req);
        out_item_t o;
        desc_t     cur;
        o   = '0;
        cur = chain_tbl[active_idx];
        case (req.kind)
            KIND_RESTART:
            begin
                clear_chain();
            end
            KIND_LOAD:
            begin
                if (fill_level >= NEXT_N)
                begin
                    o.load_rejected = 1'b1;
                    loads_refused++;
                end
                else
                begin
                    // first load of a chain wipes whatever was left behind
                    if (fill_level == 0)
                        clear_table();
                    chain_tbl[fill_level] = req.desc;
                    fill_level++;
                    if (fill_level == 1)
                        enter_desc('0);
                end
            end
            KIND_TICK:
            begin
                if (req.enable && cur.mode != MODE_SUSPENDED)
                begin
                    if (cur.mode == MODE_TRANSFER)
                    begin
                        o.mem_addr = cur_addr;
                        if (dir_s2mm)
                        begin
                            o.mem_op     = OP_WRITE;
                            o.write_data = req.stream_data;
                            writes_seen++;
                        end
                        else
                        begin
                            o.mem_op = OP_READ;
                            reads_seen++;
                        end
                        cur_addr = cur_addr + cur.stride;
                    end
                    else
                    begin
                        o.stream_zero = !dir_s2mm;
                    end
                    // a count of zero wraps and runs the full range
                    ticks_left = ticks_left - 1'b1;
                    if (ticks_left == '0)
                    begin
                        done_flag = 1'b1;
                        descs_completed++;
                        enter_desc(cur.next);
                    end
                end
                else
                begin
                    o.stream_zero = !dir_s2mm;
                end
            end
            default:
            begin
            end
        endcase
        o.done_res = done_flag;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        in_item_t  req;
        if (!rst_n)
        begin
            clear_chain();
            dir_s2mm = 1'b0;
            expected_q.delete();
        end
        else
        begin
            if (result.valid === 1'b1 && result.ready === 1'b1)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result with no request outstanding",
                                    32'(result.mem_addr), 32'd0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    results_checked++;
                    if (result.mem_op !== want.mem_op)
                        report_mismatch("mem_op", 32'(result.mem_op), 32'(want.mem_op));
                    if (result.mem_addr !== want.mem_addr)
                        report_mismatch("mem_addr", 32'(result.mem_addr),
                                        32'(want.mem_addr));
                    if (result.write_data !== want.write_data)
                        report_mismatch("write_data", result.write_data, want.write_data);
                    if (result.stream_zero !== want.stream_zero)
                        report_mismatch("stream_zero", 32'(result.stream_zero),
                                        32'(want.stream_zero));
                    if (result.done_res !== want.done_res)
                        report_mismatch("done_res", 32'(result.done_res),
                                        32'(want.done_res));
                    if (result.load_rejected !== want.load_rejected)
                        report_mismatch("load_rejected", 32'(result.load_rejected),
                                        32'(want.load_rejected));
                end
            end
            if (cfg_we)
                dir_s2mm = cfg_wdata;
            if (item.valid === 1'b1 && item.ready === 1'b1)
            begin
                req.kind        = item.kind;
                req.enable      = item.enable;
                req.stream_data = item.stream_data;
                req.desc.next   = item.desc_next;
                req.desc.start  = item.desc_start;
                req.desc.mode   = item.desc_mode;
                req.desc.count  = item.desc_count;
                req.desc.stride = item.desc_stride;
                expected_q.insert(expected_q.size(), step_sequencer(req));
            end
        end
        outstanding = expected_q.size();
    end

endmodule

[tb/sv/tb_descriptor_chain_dma_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_descriptor_chain_dma_sequencer_top
// Drives requests into the descriptor chain DMA sequencer: a directed pass
// over table fill, every descriptor mode and the chain corner cases, then
// random chains in both directions under three idling mixes, and finally
// a short run on a zero-count descriptor whose counter wraps. The monitor
// beside the block checks every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_descriptor_chain_dma_sequencer_top;
    import dcds_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int WRAP_TICKS   = 24;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    logic rx_hold_req;
    int   tx_idle_pct;
    int   rx_stall_pct;
    int   cycle_count;
    int   sent_count;

    int fail_count;
    int outstanding;
    int results_checked;
    int reads_seen;
    int writes_seen;
    int descs_completed;
    int loads_refused;

    dcds_in_if  item_ch ();
    dcds_out_if result_ch ();

    descriptor_chain_dma_sequencer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    dcds_sequence_monitor sequence_mon (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .item            (item_ch),
        .result          (result_ch),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .reads_seen      (reads_seen),
        .writes_seen     (writes_seen),
        .descs_completed (descs_completed),
        .loads_refused   (loads_refused)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("** descriptor_chain_dma_sequencer_top: FAILED **");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic desc_t random_desc();
        desc_t d;
        d.next   = NEXT_W'($urandom());
        d.start  = ADDR_W'($urandom());
        d.mode   = MODE_W'($urandom());
        d.count  = COUNT_W'($urandom());
        d.stride = ADDR_W'($urandom());
        return d;
    endfunction

    // descriptor for a chain of span entries: mostly short transfers
    function automatic desc_t chain_desc(input int span);
        desc_t d;
        int    roll;
        d      = random_desc();
        d.next = NEXT_W'($urandom_range(span - 1));
        roll   = $urandom_range(99);
        d.mode = roll < 60 ? MODE_TRANSFER :
                 roll < 78 ? MODE_WAIT :
                 roll < 94 ? MODE_FORWARD : MODE_SUSPENDED;
        if ($urandom_range(99) < 90)
            d.count = COUNT_W'($urandom_range(1, 5));
        return d;
    endfunction

    task automatic issue_request(input logic [KIND_W-1:0] k, input logic en,
                                 input logic [DATA_W-1:0] sdata, input desc_t d);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= k;
        item_ch.enable      <= en;
        item_ch.stream_data <= sdata;
        item_ch.desc_next   <= d.next;
        item_ch.desc_start  <= d.start;
        item_ch.desc_mode   <= d.mode;
        item_ch.desc_count  <= d.count;
        item_ch.desc_stride <= d.stride;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        if (k != KIND_UNUSED)
            sent_count++;
    endtask

    task automatic tick(input logic en, input logic [DATA_W-1:0] sdata);
        issue_request(KIND_TICK, en, sdata, random_desc());
    endtask

    task automatic load_desc(input desc_t d);
        issue_request(KIND_LOAD, 1'($urandom_range(1)), $urandom(), d);
    endtask

    task automatic restart_chain();
        issue_request(KIND_RESTART, 1'($urandom_range(1)), $urandom(), random_desc());
    endtask

    // stop offering and wait until the monitor holds no open request
    task automatic wait_results_drained();
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_direction(input logic dir);
        cfg_we    <= 1'b1;
        cfg_wdata <= dir;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one chain: optional restart, a batch of loads, then mostly ticks
    task automatic run_chain();
        int n_loads;
        int n_ticks;
        int span;
        int roll;
        if ($urandom_range(3) != 0)
        begin
            if ($urandom_range(9) == 0)
                wait_results_drained();
            restart_chain();
        end
        n_loads = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
        span    = (n_loads > NEXT_N) ? NEXT_N : n_loads;
        for (int i = 0; i < n_loads; i++)
        begin
            load_desc(chain_desc(span));
        end
        n_ticks = $urandom_range(8, 40);
        for (int i = 0; i < n_ticks; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                issue_request(KIND_UNUSED, 1'($urandom_range(1)), $urandom(), random_desc());
            else if (roll < 6)
                load_desc(chain_desc(span));
            else
                tick(roll >= 14, $urandom());
        end
    endtask

    task automatic run_random(input int n_items);
        int first;
        first = sent_count;
        while (sent_count - first < n_items)
        begin
            run_chain();
        end
    endtask

    initial
    begin
        desc_t d;
        item_ch.valid       <= 1'b0;
        item_ch.kind        <= KIND_TICK;
        item_ch.enable      <= 1'b0;
        item_ch.stream_data <= '0;
        item_ch.desc_next   <= '0;
        item_ch.desc_start  <= '0;
        item_ch.desc_mode   <= MODE_SUSPENDED;
        item_ch.desc_count  <= '0;
        item_ch.desc_stride <= '0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= 1'b0;
        rst_n               <= 1'b0;
        rx_hold_req  = 1'b0;
        tx_idle_pct  = 21;
        rx_stall_pct = 45;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass, stream to memory
        write_direction(1'b1);
        tick(1'b1, 32'hFFFF_FFFF);
        issue_request(KIND_UNUSED, 1'b1, 32'hFFFF_FFFF,
                      '{next: '1, start: '1, mode: MODE_WAIT, count: '1, stride: '1});
        load_desc('{next: 4'd1, start: 16'hFFFF, mode: MODE_TRANSFER, count: 16'd2,
                    stride: 16'hFFFF});
        load_desc('{next: 4'd2, start: 16'h0000, mode: MODE_WAIT, count: 16'd1,
                    stride: 16'h0000});
        load_desc('{next: 4'd3, start: 16'h8000, mode: MODE_FORWARD, count: 16'd1,
                    stride: 16'h0001});
        // points past the filled part of the table, lands on a suspended entry
        load_desc('{next: 4'd15, start: 16'h1234, mode: MODE_TRANSFER, count: 16'd1,
                    stride: 16'h0000});
        tick(1'b0, 32'hFFFF_FFFF);
        tick(1'b1, 32'hFFFF_FFFF);
        tick(1'b1, 32'h0000_0000);
        tick(1'b1, $urandom());
        tick(1'b1, $urandom());
        tick(1'b1, $urandom());
        tick(1'b1, $urandom());
        for (int i = 4; i < NEXT_N; i++)
        begin
            d = chain_desc(NEXT_N);
            if (i == NEXT_N - 1)
            begin
                d.mode  = MODE_WAIT;
                d.count = '0;
            end
            load_desc(d);
        end
        // table full: this one must be refused
        load_desc(chain_desc(NEXT_N));
        tick(1'b1, $urandom());
        restart_chain();
        tick(1'b1, $urandom());

        wait_results_drained();
        write_direction(1'b0);
        rx_hold_req = 1'b1;
        run_random(RANDOM_ITEMS / 3);

        wait_results_drained();
        write_direction(1'b1);
        tx_idle_pct  = 45;
        rx_stall_pct = 21;
        run_random(RANDOM_ITEMS / 3);

        wait_results_drained();
        write_direction(1'b0);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_random(RANDOM_ITEMS / 3);

        // zero count on a self-linked transfer: the counter wraps and keeps going
        restart_chain();
        load_desc('{next: 4'd0, start: 16'h00AA, mode: MODE_TRANSFER, count: 16'd0,
                    stride: 16'h0003});
        repeat (WRAP_TICKS) tick(1'b1, $urandom());

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests and %0d checked results in both directions",
                 sent_count, results_checked);
        $display("%0d reads, %0d writes, %0d descriptors finished, %0d loads refused",
                 reads_seen, writes_seen, descs_completed, loads_refused);
        if (fail_count == 0)
            $display("** descriptor_chain_dma_sequencer_top: PASSED **");
        else
            $display("** descriptor_chain_dma_sequencer_top: FAILED **");
        $finish;
    end

endmodule

[files.f]
hw/rtl/dcds_pkg.sv
hw/rtl/dcds_if.sv
hw/rtl/dcds_ram.sv
hw/rtl/dcds_ctrl.sv
hw/rtl/dcds_datapath.sv
hw/rtl/descriptor_chain_dma_sequencer_top.sv
hw/rtl/dcds_checker.sv
tb/sv/dcds_sequence_monitor.sv
tb/sv/tb_descriptor_chain_dma_sequencer_top.sv
